/* hw/rtl/arp_address_conflict_detector_top_defines.svh */
// ----------------------------------------------------------------------------
// ARP conflict detector assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ARP_ADDRESS_CONFLICT_DETECTOR_TOP_DEFINES_SVH
`define ARP_ADDRESS_CONFLICT_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication
`define AACD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AACD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/aacd_pkg.sv */
// ----------------------------------------------------------------------------
// ARP conflict detector package
// Beat types, field constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package aacd_pkg;

    localparam int ENTRIES_DEFAULT = 16;

    localparam logic        REQ_WRITE      = 1'b0;
    localparam logic        REQ_CHECK      = 1'b1;

    localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_LEN_MAC     = 8'd6;
    localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
    localparam logic [15:0] OP_REQUEST     = 16'd1;
    localparam logic [15:0] OP_REPLY       = 16'd2;

    localparam logic [1:0]  VERDICT_NONE   = 2'd0;
    localparam logic [1:0]  VERDICT_IP     = 2'd1;
    localparam logic [1:0]  VERDICT_MAC    = 2'd2;
    localparam logic [1:0]  VERDICT_REJECT = 2'd3;

    localparam logic [1:0]  ACTION_NONE     = 2'd0;
    localparam logic [1:0]  ACTION_REPLY    = 2'd1;
    localparam logic [1:0]  ACTION_ANNOUNCE = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  entry_index;
        logic        entry_up;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [47:0] mac_value;
        logic [31:0] ip_value;
        logic [31:0] target_ip;
    } aacd_req_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [1:0]  action;
        logic [3:0]  match_index;
        logic [31:0] conflicted_ip;
        logic [47:0] peer_mac;
    } aacd_rsp_t;

    typedef enum logic [1:0] {
        EMIT_ZERO,
        EMIT_REJECT,
        EMIT_MATCH
    } aacd_emit_t;

    typedef struct packed {
        logic       load;
        logic       write;
        logic       scan_start;
        logic       scan_step;
        logic       emit;
        aacd_emit_t emit_kind;
    } aacd_cmd_t;

    typedef struct packed {
        logic is_write;
        logic hdr_ok;
        logic ip_hit;
        logic mac_hit;
        logic last;
    } aacd_sts_t;

endpackage

/* hw/rtl/aacd_ctrl.sv */
// ----------------------------------------------------------------------------
// ARP conflict detector controller
// Sequences decode, table write, header reject and the table scan.
// ----------------------------------------------------------------------------
module aacd_ctrl
    import aacd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  aacd_sts_t sts,
    output aacd_cmd_t cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_PRIME,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;

    always_comb
    begin
        cmd        = '0;
        cmd.emit_kind = EMIT_ZERO;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_write)
                begin
                    cmd.write  = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!sts.hdr_ok)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_REJECT;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_PRIME;
                end
            end
            S_PRIME:
            begin
                cmd.scan_step = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.ip_hit || sts.mac_hit)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EMIT_MATCH;
                    state_next    = S_IDLE;
                end
                else if (sts.last)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.emit;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

/* hw/rtl/aacd_datapath.sv */
// ----------------------------------------------------------------------------
// ARP conflict detector datapath
// Request register, address table, scan pointer, entry compare, result reg.
// ----------------------------------------------------------------------------
module aacd_datapath
    import aacd_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  aacd_req_t req,
    input  aacd_cmd_t cmd,
    output aacd_sts_t sts,
    output aacd_rsp_t rsp
);

    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

    aacd_req_t         req_reg;
    aacd_rsp_t         rsp_reg;
    logic [31:0]       ip_mem  [ENTRIES];
    logic [47:0]       mac_mem [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [IDXW-1:0]   rd_idx_reg;
    logic [IDXW-1:0]   cmp_idx_reg;
    logic [31:0]       rd_ip_reg;
    logic [47:0]       rd_mac_reg;
    logic              rd_vld_reg;
    logic              wr_en;
    logic [IDXW-1:0]   wr_addr;
    logic              ip_match;

    assign wr_en   = cmd.write && (32'(req_reg.entry_index) < 32'(ENTRIES));
    assign wr_addr = IDXW'(req_reg.entry_index);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ip_mem[wr_addr]  <= req_reg.ip_value;
            mac_mem[wr_addr] <= req_reg.mac_value;
        end
        rd_ip_reg   <= ip_mem[rd_idx_reg];
        rd_mac_reg  <= mac_mem[rd_idx_reg];
        rd_vld_reg  <= valid_reg[rd_idx_reg];
        cmp_idx_reg <= rd_idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= req_reg.entry_up;
            end
            if (cmd.scan_start)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.scan_step && (rd_idx_reg != LAST_IDX))
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    assign ip_match = ((req_reg.ip_value == rd_ip_reg) && (req_reg.target_ip == rd_ip_reg))
                   || ((req_reg.ip_value == 32'd0) && (req_reg.target_ip == rd_ip_reg));

    always_comb
    begin
        sts.is_write = (req_reg.req_type == REQ_WRITE);
        sts.hdr_ok   = (req_reg.hw_type == HW_TYPE_ETH)
                    && (req_reg.proto_type == PROTO_IPV4)
                    && (req_reg.hw_len == HW_LEN_MAC)
                    && (req_reg.proto_len == PROTO_LEN_IPV4)
                    && ((req_reg.opcode == OP_REQUEST) || (req_reg.opcode == OP_REPLY))
                    && (req_reg.ip_value == req_reg.target_ip);
        sts.ip_hit   = rd_vld_reg && ip_match && (req_reg.mac_value != rd_mac_reg);
        sts.mac_hit  = rd_vld_reg && (req_reg.mac_value == rd_mac_reg);
        sts.last     = (cmp_idx_reg == LAST_IDX);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg <= '0;
            case (cmd.emit_kind)
                EMIT_REJECT:
                begin
                    rsp_reg.verdict <= VERDICT_REJECT;
                end
                EMIT_MATCH:
                begin
                    if (sts.ip_hit)
                    begin
                        rsp_reg.verdict <= VERDICT_IP;
                        rsp_reg.action  <= (req_reg.opcode == OP_REQUEST) ? ACTION_REPLY
                                                                          : ACTION_ANNOUNCE;
                    end
                    else
                    begin
                        rsp_reg.verdict <= VERDICT_MAC;
                        rsp_reg.action  <= ACTION_ANNOUNCE;
                    end
                    rsp_reg.match_index   <= 4'(cmp_idx_reg);
                    rsp_reg.conflicted_ip <= rd_ip_reg;
                    rsp_reg.peer_mac      <= req_reg.mac_value;
                end
                default:
                begin
                    rsp_reg.verdict <= VERDICT_NONE;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

/* hw/rtl/arp_address_conflict_detector_top.sv */
// ----------------------------------------------------------------------------
// ARP address conflict detector
// Local address table with ARP header validation and first-match scan.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive req and raise start; the beat is taken on a rising edge
//   with start high and busy low. busy stays high until the result is out.
//   Output beat: rsp is valid for the single cycle in which done is high.
//   The receiver has no back-pressure and must take it in that cycle.
//   A table write or a rejected header is answered from the decode state;
//   a scan ends at the first matching valid entry, or after the last slot
//   when nothing matches. busy drops in the done cycle, so the next beat
//   can be taken on the edge that takes the result. The scan reads one
//   table slot per cycle from the synchronous entry memory.
//   Reset clears every valid flag and returns the controller to idle; the
//   address memory is not cleared, and no pass over it is needed.
// ----------------------------------------------------------------------------
module arp_address_conflict_detector_top
    import aacd_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  aacd_req_t req,
    output logic      busy,
    output logic      done,
    output aacd_rsp_t rsp
);

    aacd_cmd_t cmd;
    aacd_sts_t sts;

    aacd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    aacd_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

/* hw/rtl/aacd_checker.sv */
// ----------------------------------------------------------------------------
// ARP conflict detector checker
// Port-level temporal checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "arp_address_conflict_detector_top_defines.svh"

module aacd_checker
    import aacd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input aacd_req_t req,
    input logic      busy,
    input logic      done,
    input aacd_rsp_t rsp
);

    `AACD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
    `AACD_ASSERT_NOW(a_done_ends_busy, done, !busy && $past(busy), "done without busy ending")
    `AACD_ASSERT_NEXT(a_done_pulse, done, !done, "done longer than one cycle")
    `AACD_ASSERT_NOW(a_write_latency, start && !busy && (req.req_type == REQ_WRITE), ##2 done, "write beat latency wrong")
    `AACD_ASSERT_NOW(a_no_conflict_fields, done && ((rsp.verdict == VERDICT_NONE) || (rsp.verdict == VERDICT_REJECT)), (rsp.action == ACTION_NONE) && (rsp.match_index == 4'd0) && (rsp.conflicted_ip == 32'd0) && (rsp.peer_mac == 48'd0), "nonzero fields without conflict")

endmodule

bind arp_address_conflict_detector_top aacd_checker u_checker (.*);
